// File: rtl/core/vgcld_pkg.sv
package vgcld_pkg;

  // Default grid size, cells along x, z and y
  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_LENGTH_DEF = 64;
  localparam int GRID_HEIGHT_DEF = 64;

  // Tile and coordinate widths fixed by the stream format
  localparam int TILE_W   = 8;
  localparam int COORD_W  = 16;
  localparam int OUT_CW   = 10;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  localparam logic [TILE_W-1:0] SOLID_TYPE = 8'd1;
  localparam logic [TILE_W-1:0] EMPTY_TYPE = 8'd0;

  // Request kinds carried on in_tuser
  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_SET   = 1'b1;

  typedef enum logic [1:0] {
    EV_QUERY = 2'd0,
    EV_LIGHT = 2'd1,
    EV_TILE  = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_SCAN,
    ST_LIGHT,
    ST_TILE
  } state_t;

  // Address bits for one grid axis, at least one
  function automatic int axis_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// File: rtl/core/voxel_grid_column_light_depth.sv
// Voxel grid with per-column light depth. Each request on the input stream is
// a query (in_tuser 0) or a set (in_tuser 1) of one cell at signed (x, y, z).
// A query returns one answer: solid (type equals 1) and shadowed (y below the
// column's light depth); a cell outside the grid reads as not solid and lit.
// A set inside the grid stores the tile type, rescans the column from the top
// down to height 1 and answers with a light-changed event (the lower of old and
// new depth as span_low, the higher as span_high) when the depth moved, then a
// tile-changed event with tlast high. A set outside the grid is dropped without
// any answer. Tile types live in one memory addressed {y, z, x}, light depths in
// another addressed {z, x}; both have a registered read. A query reads both
// memories on acceptance and answers from the read words. The column scan of a
// set goes through the tile memory read port, one cell per cycle from the top,
// stopping at the first solid cell; each answer waits for a free output register.
// After reset the block runs a clearing pass that writes every tile memory word
// in turn, 2**(XW + ZW + YW) words where each axis takes clog2(size) address
// bits and at least one (262144 at 64x64x64), and that fills both memories;
// in_tready stays low until it ends. A new request is taken while the last
// answer still waits on the output register.
module voxel_grid_column_light_depth
  import vgcld_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_LENGTH = GRID_LENGTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] x_coord, [31:16] y_coord, [47:32] z_coord, [55:48] tile_type
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [9:0] out_x, [19:10] out_y, [29:20] out_z, [30] solid, [31] shadowed,
  // [41:32] span_low, [51:42] span_high, [55:52] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] event_kind
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  localparam int XW       = axis_bits(GRID_WIDTH);
  localparam int ZW       = axis_bits(GRID_LENGTH);
  localparam int YW       = axis_bits(GRID_HEIGHT);
  localparam int DW       = YW;
  localparam int CELL_AW  = XW + ZW + YW;
  localparam int COL_AW   = XW + ZW;
  localparam int FILL     = GRID_HEIGHT * 2 / 3;

  // Unpack the request
  logic [COORD_W-1:0] in_x, in_y, in_z;
  logic [TILE_W-1:0]  in_tile;
  logic               in_grid;

  assign in_x    = in_tdata[15:0];
  assign in_y    = in_tdata[31:16];
  assign in_z    = in_tdata[47:32];
  assign in_tile = in_tdata[55:48];

  // Negative coordinates have the sign bit set; the rest compare unsigned
  assign in_grid = !in_x[COORD_W-1] && (in_x < COORD_W'(GRID_WIDTH)) &&
                   !in_y[COORD_W-1] && (in_y < COORD_W'(GRID_HEIGHT)) &&
                   !in_z[COORD_W-1] && (in_z < COORD_W'(GRID_LENGTH));

  // State and control registers
  state_t               state_r, state_nxt;
  logic [CELL_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [YW-1:0]        scan_y_r, scan_y_nxt;
  logic [YW-1:0]        chk_y_r, chk_y_nxt;
  logic                 chk_valid_r, chk_valid_nxt;
  logic [DW-1:0]        new_depth_r, new_depth_nxt;

  // Captured request
  logic [OUT_CW-1:0]    x_r, y_r, z_r;
  logic                 grid_r;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]            out_user_r;
  logic                  out_last_r;

  // Memory ports
  logic                 tile_we, tile_re;
  logic [CELL_AW-1:0]   tile_waddr, tile_raddr;
  logic [TILE_W-1:0]    tile_wdata, tile_rdata;
  logic                 col_we, col_re;
  logic [COL_AW-1:0]    col_waddr, col_raddr;
  logic [DW-1:0]        col_wdata, col_rdata;

  // Answer to hand over
  logic                  emit_req;
  logic                  out_free;
  event_kind_t           emit_kind;
  logic                  emit_last;
  logic                  emit_solid, emit_shadow;
  logic [OUT_CW-1:0]     emit_lo, emit_hi;
  logic [OUT_DATA_W-1:0] emit_data;

  logic                  scan_hit, scan_end;
  logic [DW-1:0]         scan_depth;

  vgcld_ram #(
    .WIDTH (TILE_W),
    .DEPTH (1 << CELL_AW)
  ) u_tile_ram (
    .clk     (clk),
    .wr_en   (tile_we),
    .wr_addr (tile_waddr),
    .wr_data (tile_wdata),
    .rd_en   (tile_re),
    .rd_addr (tile_raddr),
    .rd_data (tile_rdata)
  );

  vgcld_ram #(
    .WIDTH (DW),
    .DEPTH (1 << COL_AW)
  ) u_depth_ram (
    .clk     (clk),
    .wr_en   (col_we),
    .wr_addr (col_waddr),
    .wr_data (col_wdata),
    .rd_en   (col_re),
    .rd_addr (col_raddr),
    .rd_data (col_rdata)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // The word on the tile read port belongs to height chk_y_r while chk_valid_r
  assign scan_hit   = chk_valid_r && (tile_rdata == SOLID_TYPE);
  assign scan_end   = scan_hit || (chk_valid_r && (chk_y_r == YW'(1)));
  assign scan_depth = scan_hit ? chk_y_r : '0;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    scan_y_nxt    = scan_y_r;
    chk_y_nxt     = chk_y_r;
    chk_valid_nxt = chk_valid_r;
    new_depth_nxt = new_depth_r;

    tile_we    = 1'b0;
    tile_waddr = '0;
    tile_wdata = EMPTY_TYPE;
    tile_re    = 1'b0;
    tile_raddr = '0;
    col_we     = 1'b0;
    col_waddr  = '0;
    col_wdata  = '0;
    col_re     = 1'b0;
    col_raddr  = '0;

    emit_req    = 1'b0;
    emit_kind   = EV_QUERY;
    emit_last   = 1'b1;
    emit_solid  = 1'b0;
    emit_shadow = 1'b0;
    emit_lo     = '0;
    emit_hi     = '0;

    case (state_r)
      ST_CLEAR: begin
        // Fill every cell and column with its power-up contents
        tile_we    = 1'b1;
        tile_waddr = clr_cnt_r;
        tile_wdata = (clr_cnt_r[CELL_AW-1 -: YW] <= YW'(FILL)) ? SOLID_TYPE : EMPTY_TYPE;
        col_we     = 1'b1;
        col_waddr  = clr_cnt_r[COL_AW-1:0];
        col_wdata  = DW'(FILL);
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          // The column depth read serves both the query and the old depth of a set
          col_re    = 1'b1;
          col_raddr = {in_z[ZW-1:0], in_x[XW-1:0]};
          if (in_tuser == KIND_QUERY) begin
            tile_re    = 1'b1;
            tile_raddr = {in_y[YW-1:0], in_z[ZW-1:0], in_x[XW-1:0]};
            state_nxt  = ST_QUERY;
          end else if (in_grid) begin
            tile_we       = 1'b1;
            tile_waddr    = {in_y[YW-1:0], in_z[ZW-1:0], in_x[XW-1:0]};
            tile_wdata    = in_tile;
            scan_y_nxt    = YW'(GRID_HEIGHT - 1);
            chk_valid_nxt = 1'b0;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_QUERY: begin
        emit_req    = 1'b1;
        emit_kind   = EV_QUERY;
        emit_solid  = grid_r && (tile_rdata == SOLID_TYPE);
        emit_shadow = grid_r && (y_r < OUT_CW'(col_rdata));
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Issue one cell read per cycle and check the previous one
        tile_re       = 1'b1;
        tile_raddr    = {scan_y_r, z_r[ZW-1:0], x_r[XW-1:0]};
        chk_valid_nxt = 1'b1;
        chk_y_nxt     = scan_y_r;
        if (scan_y_r != YW'(1)) begin
          scan_y_nxt = scan_y_r - 1'b1;
        end
        if (scan_end) begin
          col_we        = 1'b1;
          col_waddr     = {z_r[ZW-1:0], x_r[XW-1:0]};
          col_wdata     = scan_depth;
          new_depth_nxt = scan_depth;
          chk_valid_nxt = 1'b0;
          state_nxt     = (scan_depth != col_rdata) ? ST_LIGHT : ST_TILE;
        end
      end
      ST_LIGHT: begin
        // The depth read port still holds the old depth of this column
        emit_req  = 1'b1;
        emit_kind = EV_LIGHT;
        emit_last = 1'b0;
        emit_lo   = OUT_CW'((col_rdata < new_depth_r) ? col_rdata : new_depth_r);
        emit_hi   = OUT_CW'((col_rdata < new_depth_r) ? new_depth_r : col_rdata);
        if (out_free) begin
          state_nxt = ST_TILE;
        end
      end
      ST_TILE: begin
        emit_req  = 1'b1;
        emit_kind = EV_TILE;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign emit_data = {4'b0000, emit_hi, emit_lo, emit_shadow, emit_solid, z_r, y_r, x_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_req && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      chk_valid_r <= chk_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_y_r    <= scan_y_nxt;
    chk_y_r     <= chk_y_nxt;
    new_depth_r <= new_depth_nxt;
    // Capture the request coordinates on acceptance
    if (in_tvalid && in_tready) begin
      x_r    <= in_x[OUT_CW-1:0];
      y_r    <= in_y[OUT_CW-1:0];
      z_r    <= in_z[OUT_CW-1:0];
      grid_r <= in_grid;
    end
    if (emit_req && out_free) begin
      out_data_r <= emit_data;
      out_user_r <= emit_kind;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // No answer may leave before the clearing pass has filled the memories
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_tvalid)
    else $error("answer presented during clearing pass");

  // A light change always reports a real move of the depth and is never last
  a_light_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == EV_LIGHT)) |->
      ((out_tdata[41:32] < out_tdata[51:42]) && !out_tlast))
    else $error("light change with empty span or tlast set");

  // Solid and shadowed only ever come with a query answer
  a_flags_query_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != EV_QUERY)) |-> (out_tdata[31:30] == 2'b00))
    else $error("solid or shadowed set on an event");

  // The scan check stage runs only inside the column scan
  a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_valid_r |-> (state_r == ST_SCAN))
    else $error("scan check pending outside the column scan");

endmodule

// File: rtl/core/vgcld_ram.sv
module vgcld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // Hold the last read word while no read is issued
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
